/* hdl/tdf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tdf_pkg
// Shared widths, types and command/status records for the trial division
// factorizer.
// ----------------------------------------------------------------------------
package tdf_pkg;

    localparam int WIDTH       = 40;
    localparam int DIV_W       = 21;
    localparam int MAX_RESULTS = 40;
    localparam int CNT_W       = $clog2(WIDTH + 1);

    typedef logic [WIDTH-1:0] t_value;
    typedef logic [DIV_W-1:0] t_divisor;
    typedef logic [CNT_W-1:0] t_cnt;

    localparam t_cnt     CNT_STEPS  = t_cnt'(WIDTH);
    localparam t_cnt     CNT_LIMIT  = t_cnt'(MAX_RESULTS);
    localparam t_divisor FIRST_ODD  = t_divisor'(3);
    localparam t_value   FACTOR_TWO = t_value'(2);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic halve;
        logic div_start;
        logic take;
        logic step_f;
        logic emit_rem;
        logic finish;
        logic emit_empty;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic num_le1;
        logic n_even;
        logic k_full;
        logic div_done;
        logic sq_ok;
        logic rem_zero;
        logic n_is_one;
    } t_status;

endpackage
`default_nettype wire

/* hdl/trial_division_factorizer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// trial_division_factorizer
// Splits a 40-bit unsigned number into its prime factors, smallest first.
// ----------------------------------------------------------------------------
// Usage:
// A number is taken at a rising edge where start is high and busy is low.
// Busy then stays high until the final beat appears on the outputs, so the
// next number can be taken at the edge where that beat is captured.
// Each factor comes out as one beat: o_valid is high for exactly one cycle
// with o_factor, o_last and o_empty_res. The receiver cannot stall, so it
// must capture every beat on the cycle it appears. Factors come in ascending
// order, repeated per multiplicity, and o_last marks the final beat.
// Inputs 0 and 1 give a single beat with o_empty_res and o_last set and a
// zero factor in the cycle after the start; busy stays low for them.
// Sequence: each factor of two is split off by a halving step. Each odd trial
// division, hit or miss, has a start step, a run of the bit-serial divider
// that produces both the quotient for the square test and the remainder for
// the hit, and a decision step. After the last trial a cofactor step and a
// finish step come before the final beat is registered. A prime near 2^40
// needs about 2^19 trials.
// Reset (synchronous, active low) aborts any run and drops pending beats.
// ----------------------------------------------------------------------------
module trial_division_factorizer (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             start,
    output logic            busy,
    input  tdf_pkg::t_value i_number,
    output logic            o_valid,
    output tdf_pkg::t_value o_factor,
    output logic            o_last,
    output logic            o_empty_res
);

    // Controller and datapath talk only through these two records.
    tdf_pkg::t_cmd    cmd;
    tdf_pkg::t_status status;

    tdf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    // The datapath holds one factor back so that the last one can be
    // flagged once the run is known to be over.
    tdf_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_number    (i_number),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_valid     (o_valid),
        .o_factor    (o_factor),
        .o_last      (o_last),
        .o_empty_res (o_empty_res)
    );

endmodule
`default_nettype wire

/* hdl/tdf_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tdf_div
// Iterative restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tdf_div (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    input  tdf_pkg::t_value   i_dividend,
    input  tdf_pkg::t_divisor i_divisor,
    output logic              o_done,
    output tdf_pkg::t_value   o_quot,
    output tdf_pkg::t_divisor o_rem
);

    tdf_pkg::t_value   r_quot, n_quot;
    tdf_pkg::t_divisor r_rem, n_rem;
    tdf_pkg::t_divisor r_div, n_div;
    tdf_pkg::t_cnt     r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;

    logic [tdf_pkg::DIV_W:0] trial;
    logic [tdf_pkg::DIV_W:0] diff;
    logic                    ge;

    always_comb begin
        trial = {r_rem, r_quot[tdf_pkg::WIDTH-1]};
        diff  = trial - {1'b0, r_div};
        ge    = (trial >= {1'b0, r_div});

        n_quot = r_quot;
        n_rem  = r_rem;
        n_div  = r_div;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_quot = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
            n_cnt  = tdf_pkg::CNT_STEPS;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_quot = {r_quot[tdf_pkg::WIDTH-2:0], ge};
            n_rem  = ge ? diff[tdf_pkg::DIV_W-1:0] : trial[tdf_pkg::DIV_W-1:0];
            n_cnt  = r_cnt - tdf_pkg::t_cnt'(1);
            if (r_cnt == tdf_pkg::t_cnt'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_div  <= n_div;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

/* hdl/tdf_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tdf_datapath
// Cofactor, trial divisor, factor count, one-deep pending factor and the
// result register.
// ----------------------------------------------------------------------------
module tdf_datapath (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  tdf_pkg::t_value  i_number,
    input  tdf_pkg::t_cmd    i_cmd,
    output tdf_pkg::t_status o_status,
    output logic             o_valid,
    output tdf_pkg::t_value  o_factor,
    output logic             o_last,
    output logic             o_empty_res
);

    tdf_pkg::t_value   r_value, n_value;
    tdf_pkg::t_divisor r_divisor, n_divisor;
    tdf_pkg::t_cnt     r_k, n_k;
    tdf_pkg::t_value   r_pend, n_pend;
    logic              r_pend_valid, n_pend_valid;
    logic              r_out_valid, n_out_valid;
    tdf_pkg::t_value   r_out_factor, n_out_factor;
    logic              r_out_last, n_out_last;
    logic              r_out_empty, n_out_empty;

    logic              emit;
    tdf_pkg::t_value   emit_val;
    logic              div_done;
    tdf_pkg::t_value   div_quot;
    tdf_pkg::t_divisor div_rem;

    tdf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_value),
        .i_divisor  (r_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_comb begin
        emit = i_cmd.halve | i_cmd.take | i_cmd.emit_rem;
        if (i_cmd.halve) begin
            emit_val = tdf_pkg::FACTOR_TWO;
        end else if (i_cmd.take) begin
            emit_val = tdf_pkg::t_value'(r_divisor);
        end else begin
            emit_val = r_value;
        end

        n_value      = r_value;
        n_divisor    = r_divisor;
        n_k          = r_k;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        n_out_valid  = 1'b0;
        n_out_factor = r_out_factor;
        n_out_last   = r_out_last;
        n_out_empty  = r_out_empty;

        if (i_cmd.load) begin
            n_value      = i_number;
            n_divisor    = tdf_pkg::FIRST_ODD;
            n_k          = '0;
            n_pend_valid = 1'b0;
        end
        if (i_cmd.halve) begin
            n_value = r_value >> 1;
        end
        if (i_cmd.take) begin
            n_value = div_quot;
        end
        if (i_cmd.step_f) begin
            n_divisor = r_divisor + tdf_pkg::t_divisor'(2);
        end

        // A new factor pushes the previous one out; only the finish
        // command knows which factor is the last one.
        if (emit) begin
            n_pend       = emit_val;
            n_pend_valid = 1'b1;
            n_k          = r_k + tdf_pkg::t_cnt'(1);
            if (r_pend_valid) begin
                n_out_valid  = 1'b1;
                n_out_factor = r_pend;
                n_out_last   = 1'b0;
                n_out_empty  = 1'b0;
            end
        end else if (i_cmd.finish) begin
            n_pend_valid = 1'b0;
            n_out_valid  = 1'b1;
            n_out_factor = r_pend;
            n_out_last   = 1'b1;
            n_out_empty  = 1'b0;
        end else if (i_cmd.emit_empty) begin
            n_out_valid  = 1'b1;
            n_out_factor = '0;
            n_out_last   = 1'b1;
            n_out_empty  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_k          <= '0;
        end else begin
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            r_k          <= n_k;
        end
        r_value      <= n_value;
        r_divisor    <= n_divisor;
        r_pend       <= n_pend;
        r_out_factor <= n_out_factor;
        r_out_last   <= n_out_last;
        r_out_empty  <= n_out_empty;
    end

    always_comb begin
        o_status.num_le1  = (i_number[tdf_pkg::WIDTH-1:1] == '0);
        o_status.n_even   = ~r_value[0];
        o_status.k_full   = (r_k == tdf_pkg::CNT_LIMIT);
        o_status.div_done = div_done;
        o_status.sq_ok    = (tdf_pkg::t_value'(r_divisor) <= div_quot);
        o_status.rem_zero = (div_rem == '0);
        o_status.n_is_one = (r_value == tdf_pkg::t_value'(1));
    end

    assign o_valid     = r_out_valid;
    assign o_factor    = r_out_factor;
    assign o_last      = r_out_last;
    assign o_empty_res = r_out_empty;

endmodule
`default_nettype wire

/* hdl/tdf_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tdf_ctrl
// Sequencer for halving, odd trial divisions and the final cofactor.
// ----------------------------------------------------------------------------
module tdf_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              start,
    input  tdf_pkg::t_status i_status,
    output tdf_pkg::t_cmd    o_cmd,
    output logic             busy
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_TWOS  = 3'd1;
    localparam logic [2:0] ST_DIVS  = 3'd2;
    localparam logic [2:0] ST_DIVW  = 3'd3;
    localparam logic [2:0] ST_CHECK = 3'd4;
    localparam logic [2:0] ST_REM   = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    if (i_status.num_le1) begin
                        o_cmd.emit_empty = 1'b1;
                    end else begin
                        n_state = ST_TWOS;
                    end
                end
            end
            ST_TWOS: begin
                if (i_status.n_even && !i_status.k_full) begin
                    o_cmd.halve = 1'b1;
                end else begin
                    n_state = ST_DIVS;
                end
            end
            ST_DIVS: begin
                if (i_status.k_full) begin
                    n_state = ST_FIN;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIVW;
                end
            end
            ST_DIVW: begin
                if (i_status.div_done) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                // The quotient gives the square test, the remainder the hit.
                if (!i_status.sq_ok) begin
                    n_state = ST_REM;
                end else if (i_status.rem_zero) begin
                    o_cmd.take = 1'b1;
                    n_state    = ST_DIVS;
                end else begin
                    o_cmd.step_f = 1'b1;
                    n_state      = ST_DIVS;
                end
            end
            ST_REM: begin
                if (!i_status.n_is_one && !i_status.k_full) begin
                    o_cmd.emit_rem = 1'b1;
                end
                n_state = ST_FIN;
            end
            ST_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != ST_IDLE);

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the trial division factorizer.
// Numbers are sent through the start/busy handshake. A built-in predictor
// splits each accepted number into its prime factors and queues the expected
// beats. A checker compares every output beat, field by field, against the
// oldest queued beat. The stimulus is a directed part followed by random
// numbers built from small primes, which keeps the trial loop short.
// ----------------------------------------------------------------------------
module tb;

    // A factor list beat as the block should deliver it.
    typedef struct {
        tdf_pkg::t_value factor;
        logic            last;
        logic            empty_res;
    } t_factor_beat;

    // This bound on the whole simulation lies well above what a correct run
    // needs, so it only trips on a hang.
    localparam int CYCLE_LIMIT    = 4000000;
    localparam int MAX_REPORTED   = 10;
    localparam int DRAIN_CYCLES   = 200;
    localparam int N_SMALL_PRIMES = 31;

    localparam int SMALL_PRIMES [N_SMALL_PRIMES] = '{
        2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53,
        59, 61, 67, 71, 73, 79, 83, 89, 97, 101, 103, 107, 109, 113, 127
    };

    logic            i_clk = 1'b0;
    logic            i_rst_n;
    logic            start;
    logic            busy;
    tdf_pkg::t_value i_number;
    logic            o_valid;
    tdf_pkg::t_value o_factor;
    logic            o_last;
    logic            o_empty_res;

    // Expected beats, oldest first.
    t_factor_beat pending_factors [$];
    t_factor_beat exp_beat;

    int mismatches  = 0;
    int cycle_count = 0;
    // Chance in percent, tried again after each idle cycle, that the sender waits before a number.
    int sender_idle_pct = 0;

    trial_division_factorizer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_number    (i_number),
        .o_valid     (o_valid),
        .o_factor    (o_factor),
        .o_last      (o_last),
        .o_empty_res (o_empty_res)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: a run that never drains ends here as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d beats still expected",
                     cycle_count, pending_factors.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Counts a failure; only the first few are described in the log.
    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTED)
            $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // Appends one expected beat behind all others.
    function automatic void queue_beat(input t_factor_beat beat);
        pending_factors.insert(pending_factors.size(), beat);
    endfunction

    // Splits a number into prime factors exactly as the block should: twos
    // first, then odd divisors while divisor squared fits in the remaining
    // value, then whatever is left above one. The square test is done as a
    // division so that nothing overflows.
    function automatic void predict_factorization(input tdf_pkg::t_value num);
        longint unsigned remaining;
        longint unsigned divisor;
        int              produced;
        t_factor_beat    beat;

        remaining = longint'(num);
        produced  = 0;
        beat.last      = 1'b0;
        beat.empty_res = 1'b0;

        // Zero and one have no factors and give a single flagged beat.
        if (remaining <= 1) begin
            beat.factor    = '0;
            beat.last      = 1'b1;
            beat.empty_res = 1'b1;
            queue_beat(beat);
            return;
        end

        while (remaining[0] == 1'b0 && produced < tdf_pkg::MAX_RESULTS) begin
            beat.factor = tdf_pkg::FACTOR_TWO;
            queue_beat(beat);
            produced++;
            remaining = remaining >> 1;
        end

        divisor = 3;
        while (produced < tdf_pkg::MAX_RESULTS && divisor <= remaining / divisor) begin
            if (remaining % divisor == 0) begin
                beat.factor = tdf_pkg::t_value'(divisor);
                queue_beat(beat);
                produced++;
                remaining = remaining / divisor;
            end else begin
                divisor = divisor + 2;
            end
        end

        // A cofactor left above one is the largest prime factor.
        if (remaining != 1 && produced < tdf_pkg::MAX_RESULTS) begin
            beat.factor = tdf_pkg::t_value'(remaining);
            queue_beat(beat);
            produced++;
        end

        pending_factors[$].last = 1'b1;
    endfunction

    // Sends one number. Called right after a rising edge; returns right after
    // the edge that accepted the number, with start still high so that a
    // following number can go out without a gap.
    task automatic send_number(input tdf_pkg::t_value num);
        int idle;

        idle = 0;
        while ($urandom_range(0, 99) < sender_idle_pct && idle < 20)
            idle++;
        if (idle > 0) begin
            start <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        start    <= 1'b1;
        i_number <= num;
        do @(posedge i_clk); while (busy);
        predict_factorization(num);
    endtask

    // Builds a number from a random cofactor below 2^14 and random small
    // primes, up to a random bit length. Prime factors above 127 can then only
    // come from the cofactor, so the odd trial loop ends within a few dozen divisors.
    function automatic tdf_pkg::t_value random_number();
        longint unsigned value;
        longint unsigned bound;
        longint unsigned prime;
        int              misses;

        if ($urandom_range(0, 9) == 0)
            return tdf_pkg::t_value'($urandom_range(0, 15));

        value  = $urandom_range(1, 16383);
        bound  = 64'd1 << $urandom_range(8, tdf_pkg::WIDTH);
        misses = 0;
        while (misses < 8) begin
            prime = SMALL_PRIMES[$urandom_range(0, N_SMALL_PRIMES - 1)];
            if (value * prime < bound)
                value = value * prime;
            else
                misses++;
        end
        return tdf_pkg::t_value'(value);
    endfunction

    // Every accepted beat is matched against the oldest expected one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_factors.size() == 0) begin
                note_mismatch($sformatf("unexpected beat factor=%0d last=%0b empty=%0b",
                                        o_factor, o_last, o_empty_res));
            end else begin
                exp_beat = pending_factors.pop_front();
                if (o_factor !== exp_beat.factor || o_last !== exp_beat.last ||
                    o_empty_res !== exp_beat.empty_res)
                    note_mismatch($sformatf(
                        "expected factor=%0d last=%0b empty=%0b, got %0d/%0b/%0b",
                        exp_beat.factor, exp_beat.last, exp_beat.empty_res,
                        o_factor, o_last, o_empty_res));
            end
        end
    end

    // Zero and one have no prime factors.
    task automatic test_empty_inputs();
        send_number(tdf_pkg::t_value'(0));
        send_number(tdf_pkg::t_value'(1));
        send_number(tdf_pkg::t_value'(0));
    endtask

    // Numbers that are mostly or only twos, up to the longest factor list
    // that fits in the input width.
    task automatic test_powers_of_two();
        send_number(tdf_pkg::t_value'(2));
        send_number(tdf_pkg::t_value'(4));
        send_number(tdf_pkg::t_value'(64'd1 << (tdf_pkg::WIDTH - 1)));
        send_number(tdf_pkg::t_value'(64'd3 << (tdf_pkg::WIDTH - 2)));
        send_number(tdf_pkg::t_value'(6));
    endtask

    // Odd divisors: exact prime squares at the edge of the square test, a
    // repeated odd factor, a large prime cofactor and the all-ones value.
    task automatic test_odd_factors();
        send_number(tdf_pkg::t_value'(3));
        send_number(tdf_pkg::t_value'(9));
        send_number(tdf_pkg::t_value'(25));
        send_number(tdf_pkg::t_value'(15));
        send_number(tdf_pkg::t_value'(64'd847288609443));    // three to the 25th
        send_number(tdf_pkg::t_value'(65537));
        send_number(tdf_pkg::t_value'(994009));              // 997 squared
        send_number(tdf_pkg::t_value'(64'd999983 << 20));
        send_number(tdf_pkg::t_value'(983 * 991));
        send_number('1);
        send_number(tdf_pkg::t_value'(2 * 65537));
    endtask

    task automatic test_random_numbers(input int count);
        repeat (count) send_number(random_number());
    endtask

    initial begin
        i_rst_n  = 1'b0;
        start    = 1'b0;
        i_number = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        sender_idle_pct = 24;
        test_empty_inputs();
        test_powers_of_two();
        test_odd_factors();
        test_random_numbers(27);

        sender_idle_pct = 45;
        test_random_numbers(27);

        sender_idle_pct = 0;
        test_random_numbers(27);
        start <= 1'b0;

        while (pending_factors.size() != 0)
            @(posedge i_clk);
        // Give a stray beat time to show up.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
